@@ src/tlik_pkg.sv @@
// Shared constants, beat types and tables for the two-link inverse kinematics core.
// Used by every cell module and by the top level; depends on nothing else.
package tlik_pkg;

   // Output angle format and arctangent pipeline length.
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int CORDIC_STAGES   = 16;
   localparam int STEP_W          = $clog2(CORDIC_STAGES);
   localparam int ROUND_SH        = 30 - ANGLE_FRAC_BITS;

   // Datapath widths.
   localparam int SCALE_W     = 33;
   localparam int DEN_W       = 33;
   localparam int CQ_W        = 31;
   localparam int SQRT_STEPS  = 31;
   localparam int SQRT_STEP_W = 5;
   localparam int RAD_W       = 61;
   localparam int CORDIC_W    = 56;
   localparam int ANGLE_W     = 34;

   localparam logic signed [ANGLE_W-1:0] HALF_PI   = 34'sd1686629713;
   localparam logic [CQ_W-1:0]           ONE_Q30   = 31'h4000_0000;
   localparam logic [18:0]               COORD_SAT = 19'h40000;

   // Register reset values.
   localparam logic [15:0] FULL_SCALE_RESET  = 16'd1000;
   localparam logic [15:0] UPPER_LINK_RESET  = 16'd22479;
   localparam logic [15:0] LOWER_LINK_RESET  = 16'd17498;

   typedef enum logic [1:0] {
      REG_FULL_SCALE_X = 2'd0,
      REG_FULL_SCALE_Y = 2'd1,
      REG_UPPER_LINK   = 2'd2,
      REG_LOWER_LINK   = 2'd3
   } reg_index_type;

   // One lane of the scaling divider: remainder and dividend/quotient shift word.
   typedef struct packed {
      logic [15:0]        rem;
      logic [SCALE_W-1:0] nq;
   } scale_lane_type;

   // Beat through the cosine divider.
   typedef struct packed {
      logic [DEN_W:0]     rem2;
      logic [CQ_W-1:0]    quo;
      logic               c_one;
      logic               neg;
      logic               unreach;
      logic [SCALE_W-1:0] xs;
      logic [SCALE_W-1:0] ys;
   } cdiv_beat_type;

   // Beat through the square root.
   typedef struct packed {
      logic [RAD_W-1:0]   v;
      logic [RAD_W-1:0]   res;
      logic signed [31:0] c;
      logic               unreach;
      logic [SCALE_W-1:0] xs;
      logic [SCALE_W-1:0] ys;
   } sqrt_beat_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [ANGLE_W-1:0]  z;
   } cordic_lane_type;

   // Beat through the arctangent chain: base, elbow and link-offset vectors.
   typedef struct packed {
      cordic_lane_type base;
      cordic_lane_type elbow;
      cordic_lane_type link;
      logic            unreach;
   } cordic_beat_type;

   // Arctangent of 2^-i in Q2.30.
   function automatic logic [29:0] atan_entry(input logic [4:0] i);
      logic [29:0] a;
      case (i)
         5'd0:  a = 30'h3243F6A8;
         5'd1:  a = 30'h1DAC6705;
         5'd2:  a = 30'h0FADBAFC;
         5'd3:  a = 30'h07F56EA6;
         5'd4:  a = 30'h03FEAB76;
         5'd5:  a = 30'h01FFD55B;
         5'd6:  a = 30'h00FFFAAA;
         5'd7:  a = 30'h007FFF55;
         5'd8:  a = 30'h003FFFEA;
         5'd9:  a = 30'h001FFFFD;
         5'd10: a = 30'h000FFFFF;
         5'd11: a = 30'h0007FFFF;
         5'd12: a = 30'h0003FFFF;
         5'd13: a = 30'h0001FFFF;
         5'd14: a = 30'h0000FFFF;
         5'd15: a = 30'h00007FFF;
         5'd16: a = 30'h00003FFF;
         5'd17: a = 30'h00001FFF;
         5'd18: a = 30'h00000FFF;
         5'd19: a = 30'h000007FF;
         5'd20: a = 30'h000003FF;
         5'd21: a = 30'h000001FF;
         5'd22: a = 30'h000000FF;
         5'd23: a = 30'h0000007F;
         default: a = 30'h0;
      endcase
      return a;
   endfunction

   // Moves a vector with negative x into the right half plane.
   function automatic cordic_lane_type pre_rotate(input logic signed [CORDIC_W-1:0] y,
                                                  input logic signed [CORDIC_W-1:0] x);
      cordic_lane_type l;
      if (x < 0) begin
         if (y >= 0) begin
            l.x = y;
            l.y = -x;
            l.z = HALF_PI;
         end else begin
            l.x = -y;
            l.y = x;
            l.z = -HALF_PI;
         end
      end else begin
         l.x = x;
         l.y = y;
         l.z = '0;
      end
      return l;
   endfunction

endpackage

@@ src/two_link_inverse_kinematics_core.sv @@
// Top level of the two-link planar arm inverse kinematics core.
// Depends on tlik_pkg and the scale, divider, square-root and CORDIC cell modules.
//
// Usage:
// A tablet point is offered on req_x_raw / req_y_raw with start; it is taken
// at every rising edge where start is high and busy is low. busy stays low, so
// a new point may be given in every cycle: one point per cycle sustained.
// Each point yields one result beat: rsp_valid is high for one cycle with the
// shoulder angle, elbow angle and out-of-reach flag. Results leave in order.
// Between the edge that takes a point and its result strobe lie the cell chains:
// 33 scaling-divider cells, 31 cosine-divider cells, 31 square-root cells and
// CORDIC_STAGES arctangent cells, plus eight single-stage multiply, add and
// output registers.
// The receiver takes every result beat; there is no back-pressure.
// The four registers sit on the APB-style port at byte addresses 0, 4, 8, 12
// and may only be written while no point is in flight.
// Synchronous reset clears every valid bit in the pipe and restores the
// registers to their reset values; in-flight points are dropped.
module two_link_inverse_kinematics_core import tlik_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [15:0]        req_x_raw,
   input  logic [15:0]        req_y_raw,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_shoulder_angle,
   output logic [14:0]        rsp_elbow_angle,
   output logic               rsp_unreachable,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // ---------------------------------------------------------------- registers
   logic [15:0] full_scale_x_ff, full_scale_x_in;
   logic [15:0] full_scale_y_ff, full_scale_y_in;
   logic [15:0] upper_link_ff, upper_link_in;
   logic [15:0] lower_link_ff, lower_link_in;
   logic [DEN_W-1:0] den_ff, den_in;
   reg_index_type reg_sel;
   logic          reg_write;

   assign reg_sel   = reg_index_type'(paddr[3:2]);
   assign reg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign busy      = 1'b0;

   // Register writes land at the access beat.
   always_comb begin
      full_scale_x_in = full_scale_x_ff;
      full_scale_y_in = full_scale_y_ff;
      upper_link_in   = upper_link_ff;
      lower_link_in   = lower_link_ff;
      if (reg_write) begin
         case (reg_sel)
            REG_FULL_SCALE_X: full_scale_x_in = pwdata[15:0];
            REG_FULL_SCALE_Y: full_scale_y_in = pwdata[15:0];
            REG_UPPER_LINK:   upper_link_in   = pwdata[15:0];
            REG_LOWER_LINK:   lower_link_in   = pwdata[15:0];
            default:          full_scale_x_in = full_scale_x_ff;
         endcase
      end
      den_in = {32'(upper_link_ff) * 32'(lower_link_ff), 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_x_ff <= FULL_SCALE_RESET;
         full_scale_y_ff <= FULL_SCALE_RESET;
         upper_link_ff   <= UPPER_LINK_RESET;
         lower_link_ff   <= LOWER_LINK_RESET;
      end else begin
         full_scale_x_ff <= full_scale_x_in;
         full_scale_y_ff <= full_scale_y_in;
         upper_link_ff   <= upper_link_in;
         lower_link_ff   <= lower_link_in;
      end
      den_ff <= den_in;
   end

   // Register read-back.
   always_comb begin
      case (reg_sel)
         REG_FULL_SCALE_X: prdata = {16'b0, full_scale_x_ff};
         REG_FULL_SCALE_Y: prdata = {16'b0, full_scale_y_ff};
         REG_UPPER_LINK:   prdata = {16'b0, upper_link_ff};
         REG_LOWER_LINK:   prdata = {16'b0, lower_link_ff};
         default:          prdata = '0;
      endcase
   end

   // A zero full scale divides as one.
   logic [15:0] divisor_x, divisor_y;
   logic [16:0] reach;
   assign divisor_x = (full_scale_x_ff == 16'd0) ? 16'd1 : full_scale_x_ff;
   assign divisor_y = (full_scale_y_ff == 16'd0) ? 16'd1 : full_scale_y_ff;
   assign reach     = 17'(upper_link_ff) + 17'(lower_link_ff);

   // ------------------------------------------------- stage 0: reach products
   logic           s0_valid_ff, s0_valid_in;
   scale_lane_type s0_x_ff, s0_x_in, s0_y_ff, s0_y_in;

   always_comb begin
      s0_valid_in = start && !busy;
      s0_x_in.rem = '0;
      s0_x_in.nq  = SCALE_W'(req_x_raw) * SCALE_W'(reach);
      s0_y_in.rem = '0;
      s0_y_in.nq  = SCALE_W'(req_y_raw) * SCALE_W'(reach);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
      s0_x_ff <= s0_x_in;
      s0_y_ff <= s0_y_in;
   end

   // ---------------------------------------------------- scaling divider chain
   logic           scale_valid [0:SCALE_W];
   scale_lane_type scale_x [0:SCALE_W];
   scale_lane_type scale_y [0:SCALE_W];

   assign scale_valid[0] = s0_valid_ff;
   assign scale_x[0]     = s0_x_ff;
   assign scale_y[0]     = s0_y_ff;

   for (genvar i = 0; i < SCALE_W; i++) begin : g_scale
      tlik_scale_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (scale_valid[i]),
         .in_x      (scale_x[i]),
         .in_y      (scale_y[i]),
         .divisor_x (divisor_x),
         .divisor_y (divisor_y),
         .out_valid (scale_valid[i+1]),
         .out_x     (scale_x[i+1]),
         .out_y     (scale_y[i+1])
      );
   end

   // ------------------------------------------------------ stage 1: squares
   logic               s1_valid_ff, s1_valid_in;
   logic [SCALE_W-1:0] s1_xs_ff, s1_xs_in, s1_ys_ff, s1_ys_in;
   logic [37:0]        s1_xsq_ff, s1_xsq_in, s1_ysq_ff, s1_ysq_in;
   logic [31:0]        s1_l1sq_ff, s1_l1sq_in, s1_l2sq_ff, s1_l2sq_in;
   logic [18:0]        xc, yc;

   // Coordinates far beyond reach are clipped for the cosine only.
   always_comb begin
      s1_valid_in = scale_valid[SCALE_W];
      s1_xs_in    = scale_x[SCALE_W].nq;
      s1_ys_in    = scale_y[SCALE_W].nq;
      xc = (s1_xs_in > SCALE_W'(COORD_SAT)) ? COORD_SAT : s1_xs_in[18:0];
      yc = (s1_ys_in > SCALE_W'(COORD_SAT)) ? COORD_SAT : s1_ys_in[18:0];
      s1_xsq_in  = 38'(xc) * 38'(xc);
      s1_ysq_in  = 38'(yc) * 38'(yc);
      s1_l1sq_in = 32'(upper_link_ff) * 32'(upper_link_ff);
      s1_l2sq_in = 32'(lower_link_ff) * 32'(lower_link_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_xs_ff   <= s1_xs_in;
      s1_ys_ff   <= s1_ys_in;
      s1_xsq_ff  <= s1_xsq_in;
      s1_ysq_ff  <= s1_ysq_in;
      s1_l1sq_ff <= s1_l1sq_in;
      s1_l2sq_ff <= s1_l2sq_in;
   end

   // ------------------------------------- stage 2: cosine numerator and clamp
   logic               s2_valid_ff, s2_valid_in;
   cdiv_beat_type      s2_beat_ff, s2_beat_in;
   logic [38:0]        sum_xy;
   logic [32:0]        sum_l;
   logic signed [39:0] num;
   logic [39:0]        mag;

   always_comb begin
      s2_valid_in = s1_valid_ff;
      sum_xy = 39'(s1_xsq_ff) + 39'(s1_ysq_ff);
      sum_l  = 33'(s1_l1sq_ff) + 33'(s1_l2sq_ff);
      num    = $signed({1'b0, sum_xy}) - $signed({7'b0, sum_l});
      mag    = (num < 0) ? 40'(-num) : 40'(num);
      s2_beat_in.unreach = mag > 40'(den_ff);
      s2_beat_in.c_one   = s2_beat_in.unreach || (den_ff == '0);
      s2_beat_in.neg     = num < 0;
      s2_beat_in.rem2    = s2_beat_in.c_one ? '0 : mag[DEN_W:0];
      s2_beat_in.quo     = '0;
      s2_beat_in.xs      = s1_xs_ff;
      s2_beat_in.ys      = s1_ys_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      s2_beat_ff <= s2_beat_in;
   end

   // ----------------------------------------------------- cosine divider chain
   logic          cdiv_valid [0:CQ_W];
   cdiv_beat_type cdiv_beat [0:CQ_W];

   assign cdiv_valid[0] = s2_valid_ff;
   assign cdiv_beat[0]  = s2_beat_ff;

   for (genvar i = 0; i < CQ_W; i++) begin : g_cdiv
      tlik_cdiv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cdiv_valid[i]),
         .in_beat   (cdiv_beat[i]),
         .den       (den_ff),
         .out_valid (cdiv_valid[i+1]),
         .out_beat  (cdiv_beat[i+1])
      );
   end

   // --------------------------------------------- stage 3: signed cosine, c^2
   logic               s3_valid_ff, s3_valid_in;
   logic signed [31:0] s3_c_ff, s3_c_in;
   logic [61:0]        s3_csq_ff, s3_csq_in;
   logic               s3_unreach_ff, s3_unreach_in;
   logic [SCALE_W-1:0] s3_xs_ff, s3_xs_in, s3_ys_ff, s3_ys_in;
   logic [CQ_W-1:0]    cm;

   always_comb begin
      s3_valid_in   = cdiv_valid[CQ_W];
      cm            = cdiv_beat[CQ_W].c_one ? ONE_Q30 : cdiv_beat[CQ_W].quo;
      s3_c_in       = cdiv_beat[CQ_W].neg ? -$signed({1'b0, cm}) : $signed({1'b0, cm});
      s3_csq_in     = 62'(cm) * 62'(cm);
      s3_unreach_in = cdiv_beat[CQ_W].unreach;
      s3_xs_in      = cdiv_beat[CQ_W].xs;
      s3_ys_in      = cdiv_beat[CQ_W].ys;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
      end
      s3_c_ff       <= s3_c_in;
      s3_csq_ff     <= s3_csq_in;
      s3_unreach_ff <= s3_unreach_in;
      s3_xs_ff      <= s3_xs_in;
      s3_ys_ff      <= s3_ys_in;
   end

   // -------------------------------------------- stage 4: radicand 1 - c^2
   logic          s4_valid_ff, s4_valid_in;
   sqrt_beat_type s4_beat_ff, s4_beat_in;

   always_comb begin
      s4_valid_in        = s3_valid_ff;
      s4_beat_in.v       = (RAD_W'(1) << 60) - s3_csq_ff[RAD_W-1:0];
      s4_beat_in.res     = '0;
      s4_beat_in.c       = s3_c_ff;
      s4_beat_in.unreach = s3_unreach_ff;
      s4_beat_in.xs      = s3_xs_ff;
      s4_beat_in.ys      = s3_ys_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s4_valid_in;
      end
      s4_beat_ff <= s4_beat_in;
   end

   // ------------------------------------------------------ square root chain
   logic          sqrt_valid [0:SQRT_STEPS];
   sqrt_beat_type sqrt_beat [0:SQRT_STEPS];

   assign sqrt_valid[0] = s4_valid_ff;
   assign sqrt_beat[0]  = s4_beat_ff;

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      tlik_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step      (SQRT_STEP_W'(i)),
         .in_valid  (sqrt_valid[i]),
         .in_beat   (sqrt_beat[i]),
         .out_valid (sqrt_valid[i+1]),
         .out_beat  (sqrt_beat[i+1])
      );
   end

   // ---------------------------------------- stage 5: L2 sin and L2 cos terms
   logic               s5_valid_ff, s5_valid_in;
   logic [CQ_W-1:0]    s5_s_ff, s5_s_in;
   logic signed [31:0] s5_c_ff, s5_c_in;
   logic [46:0]        s5_p1_ff, s5_p1_in;
   logic signed [48:0] s5_p2_ff, s5_p2_in;
   logic               s5_unreach_ff, s5_unreach_in;
   logic [SCALE_W-1:0] s5_xs_ff, s5_xs_in, s5_ys_ff, s5_ys_in;

   always_comb begin
      s5_valid_in   = sqrt_valid[SQRT_STEPS];
      s5_s_in       = sqrt_beat[SQRT_STEPS].res[CQ_W-1:0];
      s5_c_in       = sqrt_beat[SQRT_STEPS].c;
      s5_p1_in      = 47'(lower_link_ff) * 47'(s5_s_in);
      s5_p2_in      = 49'($signed({1'b0, lower_link_ff})) * 49'(s5_c_in);
      s5_unreach_in = sqrt_beat[SQRT_STEPS].unreach;
      s5_xs_in      = sqrt_beat[SQRT_STEPS].xs;
      s5_ys_in      = sqrt_beat[SQRT_STEPS].ys;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s5_valid_in;
      end
      s5_s_ff       <= s5_s_in;
      s5_c_ff       <= s5_c_in;
      s5_p1_ff      <= s5_p1_in;
      s5_p2_ff      <= s5_p2_in;
      s5_unreach_ff <= s5_unreach_in;
      s5_xs_ff      <= s5_xs_in;
      s5_ys_ff      <= s5_ys_in;
   end

   // ------------------------------ stage 6: vectors for the three arctangents
   logic               s6_valid_ff, s6_valid_in;
   cordic_beat_type    s6_beat_ff, s6_beat_in;
   logic signed [48:0] bx;

   always_comb begin
      s6_valid_in = s5_valid_ff;
      bx = $signed({3'b0, upper_link_ff, 30'b0}) + s5_p2_ff;
      s6_beat_in.link  = pre_rotate($signed({9'b0, s5_p1_ff}), CORDIC_W'(bx));
      s6_beat_in.elbow = pre_rotate($signed({25'b0, s5_s_ff}), CORDIC_W'(s5_c_ff));
      s6_beat_in.base  = pre_rotate($signed({23'b0, s5_ys_ff}), $signed({23'b0, s5_xs_ff}));
      s6_beat_in.unreach = s5_unreach_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s6_valid_in;
      end
      s6_beat_ff <= s6_beat_in;
   end

   // ------------------------------------------------------------ CORDIC chain
   logic            cordic_valid [0:CORDIC_STAGES];
   cordic_beat_type cordic_beat [0:CORDIC_STAGES];

   assign cordic_valid[0] = s6_valid_ff;
   assign cordic_beat[0]  = s6_beat_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      tlik_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step      (STEP_W'(i)),
         .in_valid  (cordic_valid[i]),
         .in_beat   (cordic_beat[i]),
         .out_valid (cordic_valid[i+1]),
         .out_beat  (cordic_beat[i+1])
      );
   end

   // ------------------------------------------- output: round and saturate
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] shoulder_ff, shoulder_in;
   logic [14:0]        elbow_ff, elbow_in;
   logic               unreach_ff, unreach_in;
   logic signed [35:0] th1, th1_r, th2_r;

   // Round to nearest with ties toward plus infinity.
   function automatic logic signed [35:0] round_angle(input logic signed [35:0] z);
      return (z + (36'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH;
   endfunction

   always_comb begin
      rsp_valid_in = cordic_valid[CORDIC_STAGES];
      th1   = 36'(cordic_beat[CORDIC_STAGES].base.z) - 36'(cordic_beat[CORDIC_STAGES].link.z);
      th1_r = round_angle(th1);
      th2_r = round_angle(36'(cordic_beat[CORDIC_STAGES].elbow.z));
      if (th1_r < -36'sd32768) begin
         shoulder_in = -16'sd32768;
      end else if (th1_r > 36'sd32767) begin
         shoulder_in = 16'sd32767;
      end else begin
         shoulder_in = th1_r[15:0];
      end
      if (th2_r < 0) begin
         elbow_in = '0;
      end else if (th2_r > 36'sd32767) begin
         elbow_in = 15'h7FFF;
      end else begin
         elbow_in = th2_r[14:0];
      end
      unreach_in = cordic_beat[CORDIC_STAGES].unreach;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      shoulder_ff <= shoulder_in;
      elbow_ff    <= elbow_in;
      unreach_ff  <= unreach_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_shoulder_angle = shoulder_ff;
   assign rsp_elbow_angle    = elbow_ff;
   assign rsp_unreachable    = unreach_ff;

endmodule

@@ src/tlik_scale_cell.sv @@
// One restoring-division cell of the coordinate scaler, x and y lanes side by side.
// Depends on tlik_pkg for the lane type and widths.
module tlik_scale_cell import tlik_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  scale_lane_type in_x,
   input  scale_lane_type in_y,
   input  logic [15:0]    divisor_x,
   input  logic [15:0]    divisor_y,
   output logic           out_valid,
   output scale_lane_type out_x,
   output scale_lane_type out_y
);

   logic           valid_ff, valid_in;
   scale_lane_type x_ff, x_in, y_ff, y_in;

   // Bring down one dividend bit, subtract when it fits, shift in the quotient bit.
   function automatic scale_lane_type div_step(input scale_lane_type l, input logic [15:0] d);
      logic [16:0]    t;
      logic           ge;
      scale_lane_type n;
      t     = {l.rem, l.nq[SCALE_W-1]};
      ge    = t >= {1'b0, d};
      n.rem = ge ? 16'(t - {1'b0, d}) : t[15:0];
      n.nq  = {l.nq[SCALE_W-2:0], ge};
      return n;
   endfunction

   always_comb begin
      valid_in = in_valid;
      x_in     = div_step(in_x, divisor_x);
      y_in     = div_step(in_y, divisor_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;

endmodule

@@ src/tlik_cdiv_cell.sv @@
// One quotient-bit cell of the cosine divider (Q1.30 magnitude of num / den).
// Depends on tlik_pkg for the beat type and widths.
module tlik_cdiv_cell import tlik_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  cdiv_beat_type    in_beat,
   input  logic [DEN_W-1:0] den,
   output logic             out_valid,
   output cdiv_beat_type    out_beat
);

   logic          valid_ff, valid_in;
   cdiv_beat_type beat_ff, beat_in;
   logic          ge;
   logic [DEN_W:0] diff;

   // The incoming remainder is already doubled; compare, subtract, double again.
   always_comb begin
      valid_in     = in_valid;
      beat_in      = in_beat;
      ge           = in_beat.rem2 >= {1'b0, den};
      diff         = ge ? in_beat.rem2 - {1'b0, den} : in_beat.rem2;
      beat_in.rem2 = {diff[DEN_W-1:0], 1'b0};
      beat_in.quo  = {in_beat.quo[CQ_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

@@ src/tlik_sqrt_cell.sv @@
// One result-bit cell of the digit-by-digit integer square root.
// Depends on tlik_pkg for the beat type and widths.
module tlik_sqrt_cell import tlik_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [SQRT_STEP_W-1:0] step,
   input  logic                   in_valid,
   input  sqrt_beat_type          in_beat,
   output logic                   out_valid,
   output sqrt_beat_type          out_beat
);

   logic             valid_ff, valid_in;
   sqrt_beat_type    beat_ff, beat_in;
   logic [5:0]       sh;
   logic [RAD_W-1:0] bitv;
   logic [RAD_W:0]   trial;
   logic             ge;

   // Trial bit is 4^(last step - step); keep it when the radicand covers it.
   always_comb begin
      valid_in = in_valid;
      beat_in  = in_beat;
      sh       = 6'(2 * (SQRT_STEPS - 1)) - {step, 1'b0};
      bitv     = RAD_W'(1) << sh;
      trial    = {1'b0, in_beat.res} + {1'b0, bitv};
      ge       = {1'b0, in_beat.v} >= trial;
      if (ge) begin
         beat_in.v   = in_beat.v - trial[RAD_W-1:0];
         beat_in.res = (in_beat.res >> 1) + bitv;
      end else begin
         beat_in.res = in_beat.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

@@ src/tlik_cordic_cell.sv @@
// One vectoring CORDIC micro-rotation cell for three independent vectors.
// Depends on tlik_pkg for the beat type and the arctangent table.
module tlik_cordic_cell import tlik_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [STEP_W-1:0] step,
   input  logic              in_valid,
   input  cordic_beat_type   in_beat,
   output logic              out_valid,
   output cordic_beat_type   out_beat
);

   logic            valid_ff, valid_in;
   cordic_beat_type beat_ff, beat_in;

   // Rotate toward the x axis by atan(2^-step).
   function automatic cordic_lane_type rotate(input cordic_lane_type l,
                                              input logic [STEP_W-1:0] i);
      logic signed [CORDIC_W-1:0] xsh;
      logic signed [CORDIC_W-1:0] ysh;
      logic signed [ANGLE_W-1:0]  a;
      cordic_lane_type            n;
      xsh = l.x >>> i;
      ysh = l.y >>> i;
      a   = $signed({4'b0, atan_entry(5'(i))});
      if (l.y > 0) begin
         n.x = l.x + ysh;
         n.y = l.y - xsh;
         n.z = l.z + a;
      end else begin
         n.x = l.x - ysh;
         n.y = l.y + xsh;
         n.z = l.z - a;
      end
      return n;
   endfunction

   always_comb begin
      valid_in      = in_valid;
      beat_in       = in_beat;
      beat_in.base  = rotate(in_beat.base, step);
      beat_in.elbow = rotate(in_beat.elbow, step);
      beat_in.link  = rotate(in_beat.link, step);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule
